// ----- hw/rtl/m2a_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// m2a_pkg
// Shared types and constants for the 2x2 matrix arithmetic unit.
// ----------------------------------------------------------------------------
package m2a_pkg;

   typedef logic [2:0] func_type;

   localparam func_type FUNC_ADD   = 3'd0;
   localparam func_type FUNC_SUB   = 3'd1;
   localparam func_type FUNC_SCALE = 3'd2;
   localparam func_type FUNC_PROD  = 3'd3;
   localparam func_type FUNC_INV   = 3'd4;

   // classified operation, all zero for an unused code
   typedef struct packed {
      logic add;
      logic sub;
      logic scale;
      logic prod;
      logic inv;
   } op_type;

   localparam int OP_WIDTH = $bits(op_type);

   localparam int CSR_WIDTH = 32;
   localparam logic signed [CSR_WIDTH-1:0] SCALE_RESET = 32'sh0001_0000;

   typedef struct packed {
      logic start;
      logic clr;
   } div_ctl_type;

   typedef struct packed {
      logic busy;
      logic done;
   } div_sts_type;

endpackage

// ----- hw/rtl/m2a_fifo.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// m2a_fifo
// Two-entry queue between the front and back of the matrix unit.
// ----------------------------------------------------------------------------
module m2a_fifo #(
   parameter int WIDTH = 8
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             push,
   input  logic [WIDTH-1:0] din,
   input  logic             pop,
   output logic [WIDTH-1:0] dout,
   output logic             vld,
   output logic             full
);

   logic [WIDTH-1:0] mem_ff [2];
   logic             wr_ptr_ff;
   logic             rd_ptr_ff;
   logic [1:0]       cnt_ff;
   logic [1:0]       cnt_in;

   assign vld  = (cnt_ff != 2'd0);
   assign full = (cnt_ff == 2'd2);
   assign dout = mem_ff[rd_ptr_ff];

   always_comb begin
      cnt_in = cnt_ff;
      if (push && !pop) begin
         cnt_in = cnt_ff + 2'd1;
      end else if (pop && !push) begin
         cnt_in = cnt_ff - 2'd1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         cnt_ff    <= 2'd0;
      end else begin
         cnt_ff <= cnt_in;
         if (push) begin
            wr_ptr_ff <= ~wr_ptr_ff;
         end
         if (pop) begin
            rd_ptr_ff <= ~rd_ptr_ff;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         mem_ff[wr_ptr_ff] <= din;
      end
   end

endmodule

// ----- hw/rtl/m2a_front.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// m2a_front
// Accepts transactions, classifies the opcode and holds the scale register.
// ----------------------------------------------------------------------------
module m2a_front
   import m2a_pkg::*;
#(
   parameter int ELEM_WIDTH = 32
) (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        req_valid,
   input  func_type                    req_func,
   input  logic [4*ELEM_WIDTH-1:0]     req_a,
   input  logic [4*ELEM_WIDTH-1:0]     req_b,
   input  logic                        csr_wr_en,
   input  logic [CSR_WIDTH-1:0]        csr_wr_data,
   input  logic                        q_full,
   output logic                        push,
   output logic [OP_WIDTH+8*ELEM_WIDTH-1:0] push_data,
   output logic [CSR_WIDTH-1:0]        scale
);

   logic [CSR_WIDTH-1:0] scale_ff;
   op_type               op;

   assign push  = req_valid && !q_full;
   assign scale = scale_ff;

   always_comb begin
      op = '0;
      unique case (req_func)
         FUNC_ADD:   op.add   = 1'b1;
         FUNC_SUB:   op.sub   = 1'b1;
         FUNC_SCALE: op.scale = 1'b1;
         FUNC_PROD:  op.prod  = 1'b1;
         FUNC_INV:   op.inv   = 1'b1;
         default:    op       = '0;
      endcase
   end

   assign push_data = {op, req_a, req_b};

   always_ff @(posedge clock) begin
      if (reset) begin
         scale_ff <= SCALE_RESET;
      end else if (csr_wr_en) begin
         scale_ff <= csr_wr_data;
      end
   end

endmodule

// ----- hw/rtl/m2a_div.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// m2a_div
// Restoring divider lane, one quotient bit per cycle, signed result.
// ----------------------------------------------------------------------------
module m2a_div
   import m2a_pkg::*;
#(
   parameter int NUM_WIDTH = 64,
   parameter int DEN_WIDTH = 64
) (
   input  logic                       clock,
   input  logic                       reset,
   input  div_ctl_type                ctl,
   input  logic [NUM_WIDTH-1:0]       num_abs,
   input  logic [DEN_WIDTH-1:0]       den_abs,
   input  logic                       neg,
   output div_sts_type                sts,
   output logic signed [NUM_WIDTH:0]  quo
);

   localparam int CNT_WIDTH = $clog2(NUM_WIDTH + 1);

   logic                 busy_ff;
   logic                 done_ff;
   logic [CNT_WIDTH-1:0] cnt_ff;
   logic [NUM_WIDTH-1:0] num_ff;
   logic [DEN_WIDTH-1:0] rem_ff;
   logic [DEN_WIDTH-1:0] den_ff;
   logic                 neg_ff;
   logic [DEN_WIDTH:0]   trial;
   logic [DEN_WIDTH:0]   diff;
   logic                 ge;
   logic [NUM_WIDTH:0]   mag;

   assign trial = {rem_ff, num_ff[NUM_WIDTH-1]};
   assign ge    = (trial >= {1'b0, den_ff});
   assign diff  = trial - {1'b0, den_ff};
   assign mag   = {1'b0, num_ff};
   assign quo   = neg_ff ? -$signed(mag) : $signed(mag);
   assign sts   = '{busy: busy_ff, done: done_ff};

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else if (ctl.start) begin
         busy_ff <= 1'b1;
         done_ff <= 1'b0;
         cnt_ff  <= CNT_WIDTH'(NUM_WIDTH);
      end else if (busy_ff) begin
         cnt_ff <= cnt_ff - 1'b1;
         if (cnt_ff == CNT_WIDTH'(1)) begin
            busy_ff <= 1'b0;
            done_ff <= 1'b1;
         end
      end else if (ctl.clr) begin
         done_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (ctl.start) begin
         num_ff <= num_abs;
         rem_ff <= '0;
         den_ff <= den_abs;
         neg_ff <= neg;
      end else if (busy_ff) begin
         num_ff <= {num_ff[NUM_WIDTH-2:0], ge};
         rem_ff <= ge ? diff[DEN_WIDTH-1:0] : trial[DEN_WIDTH-1:0];
      end
   end

endmodule

// ----- hw/rtl/m2a_back.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// m2a_back
// Executes queued transactions: multiply stage, combine and saturate stage
// with iterative inverse, and the result register.
// ----------------------------------------------------------------------------
module m2a_back
   import m2a_pkg::*;
#(
   parameter int FRAC_BITS  = 16,
   parameter int ELEM_WIDTH = 32
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              q_vld,
   input  logic [OP_WIDTH+8*ELEM_WIDTH-1:0]  q_data,
   output logic                              q_pop,
   input  logic [CSR_WIDTH-1:0]              scale,
   output logic                              rsp_valid,
   input  logic                              rsp_stall,
   output logic [ELEM_WIDTH-1:0]             rsp_y [4],
   output logic                              rsp_singular,
   output logic                              rsp_saturated
);

   localparam int E   = ELEM_WIDTH;
   localparam int OW  = (E > CSR_WIDTH) ? E : CSR_WIDTH;
   localparam int PW  = 2 * OW;
   localparam int NW  = E + 2 * FRAC_BITS;
   localparam int DAW = 2 * E;
   localparam int CW  = (PW > NW) ? PW + 1 : NW + 1;
   localparam logic signed [CW-1:0] MAXV = {{(CW-E+1){1'b0}}, {(E-1){1'b1}}};
   localparam logic signed [CW-1:0] MINV = ~MAXV;

   function automatic logic [E:0] sat_fn(input logic signed [CW-1:0] v);
      logic [E:0] r;
      if (v > MAXV) begin
         r = {1'b1, MAXV[E-1:0]};
      end else if (v < MINV) begin
         r = {1'b1, MINV[E-1:0]};
      end else begin
         r = {1'b0, v[E-1:0]};
      end
      return r;
   endfunction

   // queue head
   op_type                q_op;
   logic signed [E-1:0]   qa [4];
   logic signed [E-1:0]   qb [4];
   logic signed [OW-1:0]  mx [8];
   logic signed [OW-1:0]  my [8];
   logic signed [OW-1:0]  kx;

   // multiply stage
   logic                  m_vld_ff;
   op_type                m_op_ff;
   logic signed [E-1:0]   m_a_ff [4];
   logic signed [E-1:0]   m_b_ff [4];
   logic signed [PW-1:0]  m_p_ff [8];

   // combine stage
   logic signed [CW-1:0]  s [4];
   logic [E:0]            sv [4];
   logic signed [CW-1:0]  det;
   logic signed [CW-1:0]  det_n;
   logic                  det_zero;
   logic [DAW-1:0]        dabs;
   logic signed [E:0]     adjv [4];
   logic [E:0]            adj_m [4];
   logic [NW-1:0]         num_abs [4];
   logic                  need_div;
   logic                  s_rdy;
   logic                  s_fire;
   logic                  m_en;
   logic                  out_free;
   div_ctl_type           dctl;
   div_sts_type           dsts [4];
   logic signed [NW:0]    dq [4];

   // result register
   logic                  out_vld_ff;
   logic [E-1:0]          y_ff [4];
   logic                  sing_ff;
   logic                  sat_ff;

   assign q_op = op_type'(q_data[OP_WIDTH+8*E-1 -: OP_WIDTH]);
   assign kx   = OW'($signed(scale));

   always_comb begin
      for (int i = 0; i < 4; i++) begin
         qa[i] = $signed(q_data[(7-i)*E +: E]);
         qb[i] = $signed(q_data[(3-i)*E +: E]);
      end
      for (int j = 0; j < 8; j++) begin
         mx[j] = '0;
         my[j] = '0;
      end
      if (q_op.scale) begin
         for (int i = 0; i < 4; i++) begin
            mx[i] = kx;
            my[i] = OW'(qa[i]);
         end
      end else if (q_op.prod) begin
         for (int r = 0; r < 2; r++) begin
            for (int c = 0; c < 2; c++) begin
               mx[4*r+2*c]   = OW'(qa[2*r]);
               my[4*r+2*c]   = OW'(qb[c]);
               mx[4*r+2*c+1] = OW'(qa[2*r+1]);
               my[4*r+2*c+1] = OW'(qb[2+c]);
            end
         end
      end else if (q_op.inv) begin
         mx[0] = OW'(qa[0]);
         my[0] = OW'(qa[3]);
         mx[1] = OW'(qa[2]);
         my[1] = OW'(qa[1]);
      end
   end

   // pipeline control
   assign out_free = !out_vld_ff || !rsp_stall;
   assign s_rdy    = m_vld_ff && (!need_div || dsts[0].done);
   assign s_fire   = s_rdy && out_free;
   assign m_en     = !m_vld_ff || s_fire;
   assign q_pop    = q_vld && m_en;

   assign dctl.start = m_vld_ff && need_div && !dsts[0].busy && !dsts[0].done;
   assign dctl.clr   = s_fire;

   always_ff @(posedge clock) begin
      if (reset) begin
         m_vld_ff <= 1'b0;
      end else if (m_en) begin
         m_vld_ff <= q_vld;
      end
   end

   always_ff @(posedge clock) begin
      if (q_pop) begin
         m_op_ff <= q_op;
         for (int i = 0; i < 4; i++) begin
            m_a_ff[i] <= qa[i];
            m_b_ff[i] <= qb[i];
         end
         for (int j = 0; j < 8; j++) begin
            m_p_ff[j] <= mx[j] * my[j];
         end
      end
   end

   // determinant and adjugate for the inverse
   always_comb begin
      det      = CW'(m_p_ff[0]) - CW'(m_p_ff[1]);
      det_n    = -det;
      det_zero = (det == '0);
      dabs     = det[CW-1] ? det_n[DAW-1:0] : det[DAW-1:0];
      need_div = m_op_ff.inv && !det_zero;
      adjv[0]  = (E+1)'(m_a_ff[3]);
      adjv[1]  = -((E+1)'(m_a_ff[1]));
      adjv[2]  = -((E+1)'(m_a_ff[2]));
      adjv[3]  = (E+1)'(m_a_ff[0]);
      for (int i = 0; i < 4; i++) begin
         adj_m[i]   = adjv[i][E] ? -adjv[i] : adjv[i];
         num_abs[i] = {adj_m[i][E-1:0], {(2*FRAC_BITS){1'b0}}};
      end
   end

   for (genvar g = 0; g < 4; g++) begin : g_div
      m2a_div #(
         .NUM_WIDTH (NW),
         .DEN_WIDTH (DAW)
      ) u_div (
         .clock   (clock),
         .reset   (reset),
         .ctl     (dctl),
         .num_abs (num_abs[g]),
         .den_abs (dabs),
         .neg     (adjv[g][E] ^ det[CW-1]),
         .sts     (dsts[g]),
         .quo     (dq[g])
      );
   end

   always_comb begin
      for (int i = 0; i < 4; i++) begin
         s[i] = '0;
         if (m_op_ff.add) begin
            s[i] = CW'(m_a_ff[i]) + CW'(m_b_ff[i]);
         end else if (m_op_ff.sub) begin
            s[i] = CW'(m_a_ff[i]) - CW'(m_b_ff[i]);
         end else if (m_op_ff.scale) begin
            s[i] = CW'(m_p_ff[i]) >>> FRAC_BITS;
         end else if (m_op_ff.prod) begin
            s[i] = (CW'(m_p_ff[2*i]) + CW'(m_p_ff[2*i+1])) >>> FRAC_BITS;
         end else if (m_op_ff.inv && !det_zero) begin
            s[i] = CW'(dq[i]);
         end
         sv[i] = sat_fn(s[i]);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_vld_ff <= 1'b0;
      end else if (out_free) begin
         out_vld_ff <= s_rdy;
      end
   end

   always_ff @(posedge clock) begin
      if (s_fire) begin
         for (int i = 0; i < 4; i++) begin
            y_ff[i] <= sv[i][E-1:0];
         end
         sing_ff <= m_op_ff.inv && det_zero;
         sat_ff  <= sv[0][E] | sv[1][E] | sv[2][E] | sv[3][E];
      end
   end

   assign rsp_valid     = out_vld_ff;
   assign rsp_y         = y_ff;
   assign rsp_singular  = sing_ff;
   assign rsp_saturated = sat_ff;

endmodule

// ----- hw/rtl/matrix2x2_alu_core.sv -----
`timescale 1ns / 1ps
// add, subtract, scale, product: queue, multiply register, result register
// inverse: the combine stage also waits for the bit-serial divider
// one transaction per cycle if not stalled, one inverse per divider run
// a two-entry queue decouples the front from the execution back end
// reset: synchronous active high, clears control state, scale register to 1.0
// ----------------------------------------------------------------------------
// matrix2x2_alu_core
// 2x2 fixed-point matrix unit: add, subtract, scale, product and inverse.
// ----------------------------------------------------------------------------
module matrix2x2_alu_core
   import m2a_pkg::*;
#(
   parameter int FRAC_BITS  = 16,
   parameter int ELEM_WIDTH = 32
) (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         req_valid,
   output logic                         req_stall,
   input  logic [2:0]                   req_func,
   input  logic signed [ELEM_WIDTH-1:0] req_a_r0c0,
   input  logic signed [ELEM_WIDTH-1:0] req_a_r0c1,
   input  logic signed [ELEM_WIDTH-1:0] req_a_r1c0,
   input  logic signed [ELEM_WIDTH-1:0] req_a_r1c1,
   input  logic signed [ELEM_WIDTH-1:0] req_b_r0c0,
   input  logic signed [ELEM_WIDTH-1:0] req_b_r0c1,
   input  logic signed [ELEM_WIDTH-1:0] req_b_r1c0,
   input  logic signed [ELEM_WIDTH-1:0] req_b_r1c1,
   output logic                         rsp_valid,
   input  logic                         rsp_stall,
   output logic signed [ELEM_WIDTH-1:0] rsp_y_r0c0,
   output logic signed [ELEM_WIDTH-1:0] rsp_y_r0c1,
   output logic signed [ELEM_WIDTH-1:0] rsp_y_r1c0,
   output logic signed [ELEM_WIDTH-1:0] rsp_y_r1c1,
   output logic                         rsp_singular,
   output logic                         rsp_saturated,
   input  logic                         csr_wr_en,
   input  logic signed [31:0]           csr_wr_data
);

   localparam int QW = OP_WIDTH + 8 * ELEM_WIDTH;

   logic                  q_full;
   logic                  q_vld;
   logic                  q_pop;
   logic                  push;
   logic [QW-1:0]         push_data;
   logic [QW-1:0]         q_data;
   logic [CSR_WIDTH-1:0]  scale;
   logic [ELEM_WIDTH-1:0] y [4];

   assign req_stall = q_full;

   m2a_front #(
      .ELEM_WIDTH (ELEM_WIDTH)
   ) u_front (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_func    (req_func),
      .req_a       ({req_a_r0c0, req_a_r0c1, req_a_r1c0, req_a_r1c1}),
      .req_b       ({req_b_r0c0, req_b_r0c1, req_b_r1c0, req_b_r1c1}),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data),
      .q_full      (q_full),
      .push        (push),
      .push_data   (push_data),
      .scale       (scale)
   );

   m2a_fifo #(
      .WIDTH (QW)
   ) u_fifo (
      .clock (clock),
      .reset (reset),
      .push  (push),
      .din   (push_data),
      .pop   (q_pop),
      .dout  (q_data),
      .vld   (q_vld),
      .full  (q_full)
   );

   m2a_back #(
      .FRAC_BITS  (FRAC_BITS),
      .ELEM_WIDTH (ELEM_WIDTH)
   ) u_back (
      .clock         (clock),
      .reset         (reset),
      .q_vld         (q_vld),
      .q_data        (q_data),
      .q_pop         (q_pop),
      .scale         (scale),
      .rsp_valid     (rsp_valid),
      .rsp_stall     (rsp_stall),
      .rsp_y         (y),
      .rsp_singular  (rsp_singular),
      .rsp_saturated (rsp_saturated)
   );

   assign rsp_y_r0c0 = y[0];
   assign rsp_y_r0c1 = y[1];
   assign rsp_y_r1c0 = y[2];
   assign rsp_y_r1c1 = y[3];

`ifndef ASSERT_OFF
   a_sing_no_sat: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_singular |-> !rsp_saturated)
      else $error("singular result flagged as saturated");

   a_sing_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_singular |-> (rsp_y_r0c0 == '0) && (rsp_y_r0c1 == '0)
                                    && (rsp_y_r1c0 == '0) && (rsp_y_r1c1 == '0))
      else $error("singular result with nonzero elements");

   a_reset_idle: assert property (@(posedge clock)
      $past(reset) |-> !rsp_valid && !req_stall)
      else $error("result or stall present right after reset");
`endif

endmodule

// ----- tb/tb_matrix2x2_alu_core.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_matrix2x2_alu_core
// Self-checking bench for the 2x2 matrix unit: a directed table of edge
// cases, then random operations under random idling on both sides, with a
// long receiver hold-off. The scale register is changed between phases.
// ----------------------------------------------------------------------------
module tb_matrix2x2_alu_core
   import m2a_pkg::*;
();

   localparam int FB = 16;
   localparam int EW = 32;
   localparam int WDOG_LIMIT = 20000;
   localparam int DRAIN_CYCLES = 100;
   localparam int HOLD_CYCLES = 60;
   localparam logic signed [EW-1:0] EMAX = 32'sh7fff_ffff;
   localparam logic signed [EW-1:0] EMIN = 32'sh8000_0000;

   typedef struct {
      logic [2:0]           func;
      logic signed [EW-1:0] a [4];
      logic signed [EW-1:0] b [4];
   } mat_req_type;

   typedef struct {
      logic signed [EW-1:0] y [4];
      logic                 singular;
      logic                 saturated;
   } mat_rsp_type;

   typedef struct {
      mat_req_type req;
      logic        known;
      mat_rsp_type rsp;
   } table_row_type;

   logic clock, reset;
   logic req_valid, req_stall;
   logic [2:0] req_func;
   logic signed [EW-1:0] req_a [4];
   logic signed [EW-1:0] req_b [4];
   logic rsp_valid, rsp_stall;
   logic signed [EW-1:0] rsp_y_r0c0, rsp_y_r0c1, rsp_y_r1c0, rsp_y_r1c1;
   logic rsp_singular, rsp_saturated;
   logic csr_wr_en;
   logic signed [31:0] csr_wr_data;

   logic signed [31:0] scale_k;
   mat_rsp_type expected_q [$];
   int errors = 0;
   int n_sent = 0, n_checked = 0, n_sat = 0, n_sing = 0;
   int idle_cycles = 0;
   bit hold_off = 0;

   matrix2x2_alu_core uut (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_stall(req_stall), .req_func(req_func),
      .req_a_r0c0(req_a[0]), .req_a_r0c1(req_a[1]),
      .req_a_r1c0(req_a[2]), .req_a_r1c1(req_a[3]),
      .req_b_r0c0(req_b[0]), .req_b_r0c1(req_b[1]),
      .req_b_r1c0(req_b[2]), .req_b_r1c1(req_b[3]),
      .rsp_valid(rsp_valid), .rsp_stall(rsp_stall),
      .rsp_y_r0c0(rsp_y_r0c0), .rsp_y_r0c1(rsp_y_r0c1),
      .rsp_y_r1c0(rsp_y_r1c0), .rsp_y_r1c1(rsp_y_r1c1),
      .rsp_singular(rsp_singular), .rsp_saturated(rsp_saturated),
      .csr_wr_en(csr_wr_en), .csr_wr_data(csr_wr_data)
   );

   initial begin
      clock = 0;
      forever #5 clock = ~clock;
   end

   function automatic logic signed [EW-1:0] clamp(logic signed [127:0] v,
                                                  inout logic sat);
      if (v > 128'(EMAX)) begin
         sat = 1;
         return EMAX;
      end
      if (v < 128'(EMIN)) begin
         sat = 1;
         return EMIN;
      end
      return v[EW-1:0];
   endfunction

   function automatic mat_rsp_type matrix_result(mat_req_type r, logic signed [31:0] k);
      mat_rsp_type o;
      logic signed [127:0] a [4];
      logic signed [127:0] b [4];
      logic signed [127:0] v [4];
      logic signed [127:0] det, num, q;
      logic sat;
      sat = 0;
      for (int i = 0; i < 4; i++) begin
         a[i] = r.a[i];
         b[i] = r.b[i];
         v[i] = 0;
      end
      o.singular = 0;
      case (r.func)
         FUNC_ADD: for (int i = 0; i < 4; i++) v[i] = a[i] + b[i];
         FUNC_SUB: for (int i = 0; i < 4; i++) v[i] = a[i] - b[i];
         FUNC_SCALE: for (int i = 0; i < 4; i++) v[i] = (128'(k) * a[i]) >>> FB;
         FUNC_PROD: begin
            v[0] = (a[0] * b[0] + a[1] * b[2]) >>> FB;
            v[1] = (a[0] * b[1] + a[1] * b[3]) >>> FB;
            v[2] = (a[2] * b[0] + a[3] * b[2]) >>> FB;
            v[3] = (a[2] * b[1] + a[3] * b[3]) >>> FB;
         end
         FUNC_INV: begin
            det = a[0] * a[3] - a[2] * a[1];
            if (det == 0) o.singular = 1;
            else begin
               for (int i = 0; i < 4; i++) begin
                  case (i)
                     0: num = a[3];
                     1: num = -a[1];
                     2: num = -a[2];
                     default: num = a[0];
                  endcase
                  num = num <<< (2 * FB);
                  q = num / det;
                  v[i] = q;
               end
            end
         end
         default: ;
      endcase
      for (int i = 0; i < 4; i++) o.y[i] = clamp(v[i], sat);
      o.saturated = sat;
      return o;
   endfunction

   task automatic write_scale(logic signed [31:0] k);
      csr_wr_en   <= 1;
      csr_wr_data <= k;
      @(posedge clock);
      csr_wr_en <= 0;
      scale_k = k;
   endtask

   task automatic send(mat_req_type r, logic known, mat_rsp_type exp_rsp);
      int gap;
      gap = $urandom_range(0, 5);
      if ($urandom_range(0, 3) == 0) gap = 0;
      if (gap != 0) begin
         req_valid <= 0;
         repeat (gap) @(posedge clock);
      end
      req_valid <= 1;
      req_func  <= r.func;
      for (int i = 0; i < 4; i++) begin
         req_a[i] <= r.a[i];
         req_b[i] <= r.b[i];
      end
      @(posedge clock);
      while (req_stall) @(posedge clock);
      expected_q.push_back(known ? exp_rsp : matrix_result(r, scale_k));
      n_sent++;
   endtask

   task automatic wait_drained();
      req_valid <= 0;
      while (expected_q.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   function automatic logic signed [EW-1:0] rand_elem();
      case ($urandom_range(0, 7))
         0: return EMAX;
         1: return EMIN;
         2: return 0;
         3: return $signed($urandom_range(0, 'h3ffff)) - 'sh20000;
         4: return $signed($urandom_range(0, 'h7ff)) - 'sh400 <<< FB;
         default: return $urandom;
      endcase
   endfunction

   function automatic mat_req_type rand_req();
      mat_req_type r;
      r.func = ($urandom_range(0, 15) == 0) ? 3'($urandom_range(5, 7))
                                           : 3'($urandom_range(0, 4));
      for (int i = 0; i < 4; i++) begin
         r.a[i] = rand_elem();
         r.b[i] = rand_elem();
      end
      if (r.func == FUNC_INV && $urandom_range(0, 4) == 0) begin
         r.a[2] = r.a[0];
         r.a[3] = r.a[1];
      end
      return r;
   endfunction

   function automatic table_row_type row(logic [2:0] f, logic signed [EW-1:0] av,
                                         logic signed [EW-1:0] bv, logic known,
                                         logic signed [EW-1:0] yv, logic sg,
                                         logic st);
      table_row_type t;
      t.req.func = f;
      for (int i = 0; i < 4; i++) begin
         t.req.a[i] = av;
         t.req.b[i] = bv;
         t.rsp.y[i] = yv;
      end
      t.known = known;
      t.rsp.singular = sg;
      t.rsp.saturated = st;
      return t;
   endfunction

   // receiver: random wait per transaction, one long hold-off on request
   initial begin
      int wait_n;
      rsp_stall = 1;
      @(negedge reset);
      forever begin
         if (hold_off) begin
            rsp_stall <= 1;
            repeat (HOLD_CYCLES) @(posedge clock);
            hold_off = 0;
         end
         wait_n = $urandom_range(0, 5);
         if (wait_n != 0) begin
            rsp_stall <= 1;
            repeat (wait_n) @(posedge clock);
         end
         rsp_stall <= 0;
         @(posedge clock);
         while (!rsp_valid) @(posedge clock);
      end
   end

   always @(posedge clock) begin
      mat_rsp_type e;
      logic signed [EW-1:0] got [4];
      if (!reset && rsp_valid && !rsp_stall) begin
         got = '{rsp_y_r0c0, rsp_y_r0c1, rsp_y_r1c0, rsp_y_r1c1};
         n_checked++;
         if (expected_q.size() == 0) begin
            $display("%0t: unexpected transaction", $time);
            errors++;
         end else begin
            e = expected_q.pop_front();
            n_sat += e.saturated;
            n_sing += e.singular;
            for (int i = 0; i < 4; i++)
               if (got[i] !== e.y[i]) begin
                  $display("%0t: y[%0d] exp %h got %h", $time, i, e.y[i], got[i]);
                  errors++;
               end
            if (rsp_singular !== e.singular) begin
               $display("%0t: singular exp %b got %b", $time, e.singular, rsp_singular);
               errors++;
            end
            if (rsp_saturated !== e.saturated) begin
               $display("%0t: saturated exp %b got %b", $time, e.saturated,
                        rsp_saturated);
               errors++;
            end
         end
      end
   end

   // watchdog
   always @(posedge clock) begin
      if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall)) idle_cycles <= 0;
      else idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= WDOG_LIMIT) begin
         $display("%0t: timeout", $time);
         $display("FAIL matrix2x2_alu_core");
         $finish;
      end
   end

   initial begin
      table_row_type dir [$];
      logic signed [31:0] scales [6];
      mat_rsp_type none;
      reset = 1;
      req_valid = 0;
      req_func = 0;
      for (int i = 0; i < 4; i++) begin
         req_a[i] = 0;
         req_b[i] = 0;
      end
      csr_wr_en = 0;
      csr_wr_data = 0;
      scale_k = SCALE_RESET;
      none = '{y: '{0, 0, 0, 0}, singular: 0, saturated: 0};
      repeat (10) @(posedge clock);
      reset <= 0;
      @(posedge clock);

      dir.push_back(row(FUNC_ADD, 0, 0, 1, 0, 0, 0));
      dir.push_back(row(FUNC_ADD, EMAX, EMAX, 1, EMAX, 0, 1));
      dir.push_back(row(FUNC_ADD, EMIN, EMIN, 1, EMIN, 0, 1));
      dir.push_back(row(FUNC_ADD, EMAX, EMIN, 1, -1, 0, 0));
      dir.push_back(row(FUNC_SUB, EMIN, 1, 1, EMIN, 0, 1));
      dir.push_back(row(FUNC_SUB, EMAX, -1, 1, EMAX, 0, 1));
      dir.push_back(row(FUNC_SUB, 5, 5, 1, 0, 0, 0));
      dir.push_back(row(FUNC_SCALE, EMAX, 0, 1, EMAX, 0, 0));
      dir.push_back(row(FUNC_SCALE, EMIN, 0, 1, EMIN, 0, 0));
      dir.push_back(row(FUNC_SCALE, -1, 0, 1, -1, 0, 0));
      dir.push_back(row(FUNC_PROD, EMAX, EMAX, 0, 0, 0, 0));
      dir.push_back(row(FUNC_PROD, EMIN, EMIN, 0, 0, 0, 0));
      dir.push_back(row(FUNC_PROD, -1, 1, 0, 0, 0, 0));
      dir.push_back(row(FUNC_INV, 'sh10000, 0, 1, 0, 1, 0));
      dir.push_back(row(FUNC_INV, EMIN, 0, 1, 0, 1, 0));
      dir.push_back(row(3'd5, EMAX, EMAX, 1, 0, 0, 0));
      dir.push_back(row(3'd6, EMIN, 1, 1, 0, 0, 0));
      dir.push_back(row(3'd7, -1, -1, 1, 0, 0, 0));
      begin
         table_row_type t;
         t = row(FUNC_INV, 0, 0, 0, 0, 0, 0);
         t.req.a = '{'sh10000, 0, 0, 'sh10000};
         dir.push_back(t);
         t.req.a = '{EMAX, EMIN, EMIN, EMIN};
         dir.push_back(t);
         t.req.a = '{1, 0, 0, 1};
         dir.push_back(t);
         t.req.a = '{EMIN, 0, 0, -1};
         dir.push_back(t);
         t = row(FUNC_PROD, 0, 0, 0, 0, 0, 0);
         t.req.a = '{'sh20000, 'sh10000, -'sh10000, 'sh30000};
         t.req.b = '{'sh8000, -'sh4000, 'sh10000, 7};
         dir.push_back(t);
      end
      foreach (dir[i]) send(dir[i].req, dir[i].known, dir[i].known ? dir[i].rsp : none);
      wait_drained();

      scales = '{32'sh7fff_ffff, 32'sh8000_0000, 0, -32'sh0001_0000, 32'sh0000_8000, 0};
      scales[5] = $urandom;
      for (int ph = 0; ph < 6; ph++) begin
         write_scale(scales[ph]);
         if (ph == 2) begin
            // receiver holds off while the sender keeps offering
            hold_off = 1;
            for (int n = 0; n < 20; n++) send(rand_req(), 0, none);
         end
         for (int n = 0; n < 270; n++) send(rand_req(), 0, none);
         wait_drained();
      end
      write_scale(SCALE_RESET);
      for (int n = 0; n < 10; n++) send(rand_req(), 0, none);
      wait_drained();

      $display("sent %0d transactions, checked %0d, saturated %0d, singular %0d",
               n_sent, n_checked, n_sat, n_sing);
      if (errors == 0 && expected_q.size() == 0) begin
         $display("PASS matrix2x2_alu_core");
      end else begin
         $display("FAIL matrix2x2_alu_core");
      end
      $finish;
   end

endmodule

// ----- matrix2x2_alu_core.f -----
hw/rtl/m2a_pkg.sv
hw/rtl/m2a_fifo.sv
hw/rtl/m2a_front.sv
hw/rtl/m2a_div.sv
hw/rtl/m2a_back.sv
hw/rtl/matrix2x2_alu_core.sv
tb/tb_matrix2x2_alu_core.sv
